FILE: sv/gregorian_days_between_core_macros.svh
// ----------------------------------------------------------------------------
// gregorian_days_between_core_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DAYS_BETWEEN_CORE_MACROS_SVH
`define GREGORIAN_DAYS_BETWEEN_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GDB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdb assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define GDB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdb assertion failed");

`endif

FILE: sv/gdb_pkg.sv
// ----------------------------------------------------------------------------
// gdb_pkg
// types, constants and calendar tables for the days-between core
// ----------------------------------------------------------------------------
package gdb_pkg;

    localparam logic [13:0] YEAR_LIMIT   = 14'd9999;
    localparam logic [3:0]  MONTHS       = 4'd12;
    localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          RECIP_SHIFT  = 19;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_A    = 2'd1;
    localparam logic [1:0] ST_BAD_B    = 2'd2;
    localparam logic [1:0] ST_REVERSED = 2'd3;

    typedef struct packed {
        logic [13:0] year_a;
        logic [3:0]  month_a;
        logic [4:0]  day_a;
        logic [13:0] year_b;
        logic [3:0]  month_b;
        logic [4:0]  day_b;
    } gdb_in_t;

    typedef struct packed {
        logic [21:0] day_count;
        logic [1:0]  status;
    } gdb_out_t;

    typedef struct packed {
        logic s2_load;
        logic s3_load;
    } gdb_ctrl_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: sv/gdb_stream_if.sv
// ----------------------------------------------------------------------------
// gdb_stream_if
// valid/ready channel carrying one item per handshake
// ----------------------------------------------------------------------------
interface gdb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/gdb_date_unit.sv
// ----------------------------------------------------------------------------
// gdb_date_unit
// two-stage date check and day-number conversion from 0000-01-01
// ----------------------------------------------------------------------------
module gdb_date_unit (
    input  logic              clk,
    input  gdb_pkg::gdb_ctrl_t ctrl,
    input  logic [13:0]       year,
    input  logic [3:0]        month,
    input  logic [4:0]        day,
    output logic [21:0]       day_num,
    output logic              ok
);

    // stage 2: constant multiplies
    logic [14:0] ceil_num;
    logic [27:0] ceil_prod;
    logic [27:0] floor_prod;
    logic [22:0] y365_next;

    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [22:0] y365_reg;
    logic [7:0]  c100_reg;
    logic [7:0]  f100_reg;

    assign ceil_num   = {1'b0, year} + 15'd99;
    assign ceil_prod  = 28'(ceil_num) * 28'(gdb_pkg::RECIP_100);
    assign floor_prod = 28'(year) * 28'(gdb_pkg::RECIP_100);
    assign y365_next  = 23'(year) * 23'(gdb_pkg::DAYS_PER_YR);

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_load)
        begin
            year_reg  <= year;
            month_reg <= month;
            day_reg   <= day;
            y365_reg  <= y365_next;
            c100_reg  <= ceil_prod[gdb_pkg::RECIP_SHIFT +: 8];
            f100_reg  <= floor_prod[gdb_pkg::RECIP_SHIFT +: 8];
        end
    end

    // stage 3: leap rule, validity, day number
    logic        div100;
    logic        leap;
    logic [4:0]  len;
    logic        ok_next;
    logic [14:0] ya_sum;
    logic [8:0]  c400_sum;
    logic [22:0] num_next;
    logic [21:0] day_num_reg;
    logic        ok_reg;

    assign div100   = (f100_reg == c100_reg);
    assign leap     = (year_reg[1:0] == 2'd0) && (!div100 || (c100_reg[1:0] == 2'd0));
    assign len      = gdb_pkg::month_len(month_reg, leap);
    assign ok_next  = (year_reg <= gdb_pkg::YEAR_LIMIT) && (month_reg != 4'd0) &&
                      (month_reg <= gdb_pkg::MONTHS) && (day_reg != 5'd0) &&
                      (day_reg <= len);
    assign ya_sum   = {1'b0, year_reg} + 15'd3;
    assign c400_sum = {1'b0, c100_reg} + 9'd3;
    assign num_next = y365_reg + 23'(ya_sum[14:2]) + 23'(c400_sum[8:2])
                    + 23'(gdb_pkg::days_before(month_reg))
                    + 23'((month_reg > 4'd2) && leap) + 23'(day_reg)
                    - 23'(c100_reg) - 23'd1;

    always_ff @(posedge clk)
    begin
        if (ctrl.s3_load)
        begin
            day_num_reg <= num_next[21:0];
            ok_reg      <= ok_next;
        end
    end

    assign day_num = day_num_reg;
    assign ok      = ok_reg;

endmodule

FILE: sv/gregorian_days_between_core.sv
// ----------------------------------------------------------------------------
// gregorian_days_between_core
// days between two proleptic gregorian dates, with validity status
// ----------------------------------------------------------------------------
// Takes one date pair per cycle when the output is not stalled and returns
// one result per pair, in order. Each item passes through an input register,
// a stage of constant multiplies (365 times
// year and the reciprocal divide by 100), a stage that forms the day numbers
// and checks the dates, and an output register holding the difference and
// status. A stall on the result channel holds every stage, and an empty stage
// always takes the item behind it.
module gregorian_days_between_core (
    input  logic      clk,
    input  logic      rst_n,
    gdb_stream_if.sink   req,
    gdb_stream_if.source rsp
);

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic s3_ready;
    logic s2_ready;
    gdb_pkg::gdb_ctrl_t ctrl;

    gdb_pkg::gdb_in_t  in_reg;
    gdb_pkg::gdb_out_t out_reg;
    gdb_pkg::gdb_out_t out_next;

    assign out_load  = !out_valid_reg || rsp.ready;
    assign s3_ready  = !s3_valid_reg || out_load;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign req.ready = !s1_valid_reg || s2_ready;

    assign ctrl.s2_load = s2_ready;
    assign ctrl.s3_load = s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (out_load)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            in_reg <= req.payload;
    end

    logic [21:0] num_a;
    logic [21:0] num_b;
    logic        ok_a;
    logic        ok_b;

    gdb_date_unit u_date_a (
        .clk     (clk),
        .ctrl    (ctrl),
        .year    (in_reg.year_a),
        .month   (in_reg.month_a),
        .day     (in_reg.day_a),
        .day_num (num_a),
        .ok      (ok_a)
    );

    gdb_date_unit u_date_b (
        .clk     (clk),
        .ctrl    (ctrl),
        .year    (in_reg.year_b),
        .month   (in_reg.month_b),
        .day     (in_reg.day_b),
        .day_num (num_b),
        .ok      (ok_b)
    );

    logic [22:0] diff;

    assign diff = {1'b0, num_b} - {1'b0, num_a};

    always_comb
    begin
        out_next.day_count = 22'd0;
        if (!ok_a)
            out_next.status = gdb_pkg::ST_BAD_A;
        else if (!ok_b)
            out_next.status = gdb_pkg::ST_BAD_B;
        else if (diff[22])
            out_next.status = gdb_pkg::ST_REVERSED;
        else
        begin
            out_next.status    = gdb_pkg::ST_OK;
            out_next.day_count = diff[21:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

FILE: sv/gdb_checker.sv
// ----------------------------------------------------------------------------
// gdb_checker
// port-level checks for the days-between core, bound to the top level
// ----------------------------------------------------------------------------
`include "gregorian_days_between_core_macros.svh"

module gdb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [13:0] year_a,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [21:0] day_count,
    input logic [1:0]  status
);

    // any error status carries a zero count
    `GDB_ASSERT_NOW(a_err_zero, rsp_valid && (status != gdb_pkg::ST_OK), day_count == 22'd0)

    // a stalled result holds
    `GDB_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(day_count) && $stable(status))

    // input backs up only behind a stalled result
    `GDB_ASSERT_NOW(a_backpressure, !req_ready, rsp_valid && !rsp_ready)

    // bad first year comes out as ST_BAD_A with a zero count when the result is not stalled
    `GDB_ASSERT_NEXT(a_latency, (req_valid && req_ready && (year_a > gdb_pkg::YEAR_LIMIT)) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid && (status == gdb_pkg::ST_BAD_A) && (day_count == 22'd0))

endmodule

bind gregorian_days_between_core gdb_checker u_gdb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .year_a    (req.payload.year_a),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .day_count (rsp.payload.day_count),
    .status    (rsp.payload.status)
);

FILE: dv/tb_gregorian_days_between_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_days_between_core
// self-checking bench for the days-between core
// ----------------------------------------------------------------------------
// A driver sends date pairs from a queue in bursts with random gaps. A
// receiver stalls in changing patterns and once holds off long enough to
// back up the pipeline. Each accepted pair is run through a day-serial
// predictor and each result is compared field by field, in order, with it.
// The stimulus opens with calendar corner cases and then runs random pairs,
// mostly valid and in order, plus reversed, corrupted and raw-noise pairs.
// ----------------------------------------------------------------------------
module tb_gregorian_days_between_core;

    localparam int RANDOM_PAIRS  = 1400;
    localparam int HOLD_START    = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_THIRD,
        RX_SPARSE
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    gdb_stream_if #(.payload_t(gdb_pkg::gdb_in_t))  req_if ();
    gdb_stream_if #(.payload_t(gdb_pkg::gdb_out_t)) rsp_if ();

    gregorian_days_between_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    gdb_pkg::gdb_in_t  pending_pairs[$];
    gdb_pkg::gdb_out_t expected_spans[$];
    gdb_pkg::gdb_out_t want_span;

    int       total_pairs    = 0;
    int       accepted_pairs = 0;
    int       fail_count     = 0;
    int       burst_left     = 0;
    int       gap_left       = 0;
    logic     hold_off       = 1'b0;
    rx_mode_t rx_mode        = RX_OPEN;
    int       rx_left        = 0;
    int       rx_phase       = 0;
    logic     rx_bit;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit leap_year(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int month_days(input int y, input int m);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic bit date_valid(input int y, input int m, input int d);
        if (y > 9999 || m < 1 || m > 12 || d < 1)
            return 1'b0;
        return d <= month_days(y, m);
    endfunction

    // days since 0000-01-01, year 0 counted as leap
    function automatic int day_serial(input int y, input int m, input int d);
        int n;
        n = 365 * y;
        if (y > 0)
            n += (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
        for (int k = 1; k < m; k++)
            n += month_days(y, k);
        return n + d - 1;
    endfunction

    function automatic gdb_pkg::gdb_out_t span_of_dates(input gdb_pkg::gdb_in_t p);
        gdb_pkg::gdb_out_t r;
        int                sa;
        int                sb;
        r.day_count = '0;
        if (!date_valid(int'(p.year_a), int'(p.month_a), int'(p.day_a)))
        begin
            r.status = gdb_pkg::ST_BAD_A;
        end
        else if (!date_valid(int'(p.year_b), int'(p.month_b), int'(p.day_b)))
        begin
            r.status = gdb_pkg::ST_BAD_B;
        end
        else
        begin
            sa = day_serial(int'(p.year_a), int'(p.month_a), int'(p.day_a));
            sb = day_serial(int'(p.year_b), int'(p.month_b), int'(p.day_b));
            if (sb < sa)
            begin
                r.status = gdb_pkg::ST_REVERSED;
            end
            else
            begin
                r.status    = gdb_pkg::ST_OK;
                r.day_count = 22'(sb - sa);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic add_pair(input int ya, input int ma, input int da,
                            input int yb, input int mb, input int db);
        gdb_pkg::gdb_in_t p;
        p.year_a  = 14'(ya);
        p.month_a = 4'(ma);
        p.day_a   = 5'(da);
        p.year_b  = 14'(yb);
        p.month_b = 4'(mb);
        p.day_b   = 5'(db);
        pending_pairs.push_back(p);
    endtask

    task automatic random_date(output int y, output int m, output int d);
        y = ($urandom_range(0, 4) == 0) ? 100 * $urandom_range(0, 99) : $urandom_range(0, 9999);
        m = $urandom_range(1, 12);
        d = ($urandom_range(0, 4) == 0) ? month_days(y, m) : $urandom_range(1, month_days(y, m));
    endtask

    task automatic break_date(inout int y, inout int m, inout int d);
        int len;
        len = month_days(y, m);
        case ($urandom_range(0, 2))
            0:       y = $urandom_range(10000, 16383);
            1:       m = $urandom_range(13, 16) % 16;
            default: d = (len == 31 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(len + 1, 31);
        endcase
    endtask

    task automatic random_pair();
        int ya, ma, da, yb, mb, db, t, kind;
        kind = $urandom_range(0, 99);
        if (kind < 90)
        begin
            random_date(ya, ma, da);
            random_date(yb, mb, db);
            if ($urandom_range(0, 3) == 0)
            begin
                yb = ya;
                if (db > month_days(yb, mb))
                    db = month_days(yb, mb);
            end
            if (kind < 80)
            begin
                if ((kind < 70) == (day_serial(yb, mb, db) < day_serial(ya, ma, da)))
                begin
                    t = ya; ya = yb; yb = t;
                    t = ma; ma = mb; mb = t;
                    t = da; da = db; db = t;
                end
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                break_date(ya, ma, da);
            end
            else
            begin
                break_date(yb, mb, db);
            end
        end
        else
        begin
            ya = $urandom_range(0, 16383);
            ma = $urandom_range(0, 15);
            da = $urandom_range(0, 31);
            yb = $urandom_range(0, 16383);
            mb = $urandom_range(0, 15);
            db = $urandom_range(0, 31);
        end
        add_pair(ya, ma, da, yb, mb, db);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid   <= 1'b0;
            req_if.payload <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                expected_spans.push_back(span_of_dates(pending_pairs.pop_front()));
                accepted_pairs++;
            end
            if (!(req_if.valid && !req_if.ready))
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    burst_left--;
                    req_if.valid   <= 1'b1;
                    req_if.payload <= pending_pairs[0];
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rx_left  = 0;
            rx_phase = 0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 160);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN:  rx_bit = 1'b1;
                RX_COIN:  rx_bit = 1'($urandom_range(0, 1));
                RX_THIRD: rx_bit = (rx_phase % 3 == 0);
                default:  rx_bit = ($urandom_range(0, 3) == 0);
            endcase
            rsp_if.ready <= rx_bit && !hold_off;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_spans.size() == 0)
            begin
                report_mismatch("result with no pair waiting",
                                int'(rsp_if.payload.day_count), 0);
            end
            else
            begin
                want_span = expected_spans.pop_front();
                if (rsp_if.payload.day_count !== want_span.day_count)
                    report_mismatch("day_count", int'(rsp_if.payload.day_count),
                                    int'(want_span.day_count));
                if (rsp_if.payload.status !== want_span.status)
                    report_mismatch("status", int'(rsp_if.payload.status),
                                    int'(want_span.status));
            end
        end
    end

    // long receiver hold-off while the driver keeps offering
    initial
    begin
        while (accepted_pairs < HOLD_START)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("gregorian_days_between_core: mismatch");
        $finish;
    end

    initial
    begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        rst_n          = 1'b0;

        add_pair(0, 1, 1, 0, 1, 1);
        add_pair(0, 1, 1, 9999, 12, 31);
        add_pair(2000, 2, 29, 2000, 3, 1);
        add_pair(1900, 2, 29, 1900, 3, 1);
        add_pair(2024, 1, 31, 1900, 2, 29);
        add_pair(0, 2, 29, 1, 3, 1);
        add_pair(2100, 2, 28, 2100, 3, 1);
        add_pair(2400, 2, 29, 2400, 12, 31);
        add_pair(2023, 12, 31, 2024, 1, 1);
        add_pair(1999, 0, 10, 2000, 1, 1);
        add_pair(1999, 13, 10, 2000, 1, 1);
        add_pair(1999, 1, 10, 2000, 15, 1);
        add_pair(1999, 1, 0, 2000, 1, 1);
        add_pair(1999, 4, 31, 2000, 1, 1);
        add_pair(1999, 1, 1, 2000, 6, 31);
        add_pair(10000, 1, 1, 10000, 1, 2);
        add_pair(1, 1, 1, 16383, 15, 31);
        add_pair(16383, 15, 31, 16383, 15, 31);
        add_pair(9999, 12, 31, 0, 1, 1);
        add_pair(2024, 3, 1, 2024, 2, 29);
        add_pair(9999, 12, 31, 9999, 12, 31);
        add_pair(8191, 7, 16, 9998, 8, 15);
        add_pair(2023, 2, 29, 2024, 2, 29);

        for (int i = 0; i < RANDOM_PAIRS; i++)
            random_pair();
        total_pairs = pending_pairs.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_pairs < total_pairs)
            @(posedge clk);
        while (expected_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("gregorian_days_between_core: match");
        else
            $display("gregorian_days_between_core: mismatch");
        $finish;
    end

endmodule
